@@ hw/rtl/irs_pkg.sv @@
// Shared types, symbol codes and greedy-conversion table for the Roman symbol converter.
`timescale 1ns / 1ps
`default_nettype none

package irs_pkg;

    localparam int ValueW  = 12;
    localparam int SymW    = 3;
    localparam int IdxW    = 4;
    localparam int NumRows = 13;
    localparam logic [ValueW-1:0] ValueMax = ValueW'(3999);

    typedef logic [SymW-1:0]   sym_t;
    typedef logic [ValueW-1:0] value_t;
    typedef logic [IdxW-1:0]   idx_t;

    localparam sym_t SYM_I = 3'd0;
    localparam sym_t SYM_V = 3'd1;
    localparam sym_t SYM_X = 3'd2;
    localparam sym_t SYM_L = 3'd3;
    localparam sym_t SYM_C = 3'd4;
    localparam sym_t SYM_D = 3'd5;
    localparam sym_t SYM_M = 3'd6;

    localparam idx_t LastRow = IdxW'(NumRows - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_ERR
    } state_t;

    // One step of the shared compare/subtract unit.
    typedef struct packed {
        logic   fire;
        sym_t   symbol;
        logic   last;
        value_t rem_next;
        idx_t   idx_next;
        logic   half_next;
    } step_t;

    // Table rows in descending weight; odd rows are subtractive pairs.
    function automatic value_t row_weight(input idx_t idx);
        value_t w;
        begin
            unique case (idx)
                4'd0:    w = ValueW'(1000);
                4'd1:    w = ValueW'(900);
                4'd2:    w = ValueW'(500);
                4'd3:    w = ValueW'(400);
                4'd4:    w = ValueW'(100);
                4'd5:    w = ValueW'(90);
                4'd6:    w = ValueW'(50);
                4'd7:    w = ValueW'(40);
                4'd8:    w = ValueW'(10);
                4'd9:    w = ValueW'(9);
                4'd10:   w = ValueW'(5);
                4'd11:   w = ValueW'(4);
                default: w = ValueW'(1);
            endcase
            return w;
        end
    endfunction

    function automatic sym_t row_first(input idx_t idx);
        sym_t s;
        begin
            unique case (idx)
                4'd0:    s = SYM_M;
                4'd1:    s = SYM_C;
                4'd2:    s = SYM_D;
                4'd3:    s = SYM_C;
                4'd4:    s = SYM_C;
                4'd5:    s = SYM_X;
                4'd6:    s = SYM_L;
                4'd7:    s = SYM_X;
                4'd8:    s = SYM_X;
                4'd9:    s = SYM_I;
                4'd10:   s = SYM_V;
                default: s = SYM_I;
            endcase
            return s;
        end
    endfunction

    function automatic sym_t row_second(input idx_t idx);
        sym_t s;
        begin
            unique case (idx)
                4'd1:    s = SYM_M;
                4'd3:    s = SYM_D;
                4'd5:    s = SYM_C;
                4'd7:    s = SYM_L;
                4'd9:    s = SYM_X;
                4'd11:   s = SYM_V;
                default: s = SYM_I;
            endcase
            return s;
        end
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/irs_step.sv @@
// Shared compare/subtract unit: one greedy step against the current table row.
`timescale 1ns / 1ps
`default_nettype none

module irs_step
    import irs_pkg::*;
(
    input  value_t rem,
    input  idx_t   idx,
    input  logic   half,
    output step_t  step
);

    value_t weight;
    value_t diff;
    logic   ge;
    logic   pair;

    assign weight = row_weight(idx);
    assign ge     = (rem >= weight);
    assign diff   = rem - weight;
    assign pair   = idx[0];

    always_comb
    begin
        step           = '0;
        step.rem_next  = rem;
        step.idx_next  = idx;
        step.half_next = half;
        step.symbol    = row_first(idx);
        if (!ge)
        begin
            // row no longer fits: move to the next lighter row
            step.idx_next = (idx == LastRow) ? idx : idx + 1'b1;
        end
        else if (pair && !half)
        begin
            step.fire      = 1'b1;
            step.half_next = 1'b1;
        end
        else
        begin
            step.fire      = 1'b1;
            step.symbol    = half ? row_second(idx) : row_first(idx);
            step.rem_next  = diff;
            step.half_next = 1'b0;
            step.last      = (diff == '0);
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/integer_to_roman_symbols.sv @@
// Top level: converts one integer request into a stream of Roman numeral symbols.
`timescale 1ns / 1ps
`default_nettype none

// Takes a 12-bit unsigned value and sends its Roman numeral one symbol per
// output transfer, tlast on the final symbol. Values of zero or above 3999
// give one transfer with tuser (invalid) and tlast set and symbol I (code 0).
// A greedy subtract unit walks a 13-row weight table (M, CM, D, ... IV, I):
// each cycle that the output register is free it either emits a symbol or
// passes over a row. The input is not ready while a request is being
// converted; the final symbol sits in an output register, so the next
// request is accepted while it waits to be taken.

module integer_to_roman_symbols
    import irs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [15:0] s_tdata,   // [11:0] value, [15:12] zero
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // [2:0] symbol, [7:3] zero
    output logic       m_tlast,
    output logic       m_tuser     // [0] invalid
);

    state_t state_reg, state_next;
    value_t rem_reg;
    idx_t   idx_reg;
    logic   half_reg;
    logic   out_valid_reg;
    sym_t   out_sym_reg;
    logic   out_last_reg;
    logic   out_inv_reg;

    value_t in_value;
    logic   in_accept;
    logic   in_bad;
    logic   out_free;
    logic   adv;
    step_t  step;

    logic   out_load;
    sym_t   out_sym_next;
    logic   out_last_next;
    logic   out_inv_next;

    assign in_value  = s_tdata[ValueW-1:0];
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign in_bad    = (in_value == '0) || (in_value > ValueMax);
    assign out_free  = !out_valid_reg || m_tready;
    assign adv       = (state_reg == ST_RUN) && out_free;

    irs_step u_step (
        .rem  (rem_reg),
        .idx  (idx_reg),
        .half (half_reg),
        .step (step)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = in_bad ? ST_ERR : ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (adv && step.fire && step.last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_ERR:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        out_load      = 1'b0;
        out_sym_next  = SYM_I;
        out_last_next = 1'b0;
        out_inv_next  = 1'b0;
        unique case (state_reg)
            ST_RUN:
            begin
                out_load      = adv && step.fire;
                out_sym_next  = step.symbol;
                out_last_next = step.last;
            end
            ST_ERR:
            begin
                out_load      = out_free;
                out_last_next = 1'b1;
                out_inv_next  = 1'b1;
            end
            default:
            begin
                out_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            rem_reg  <= in_value;
            idx_reg  <= '0;
            half_reg <= 1'b0;
        end
        else if (adv)
        begin
            rem_reg  <= step.rem_next;
            idx_reg  <= step.idx_next;
            half_reg <= step.half_next;
        end
        if (out_load)
        begin
            out_sym_reg  <= out_sym_next;
            out_last_reg <= out_last_next;
            out_inv_reg  <= out_inv_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_sym_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_inv_reg;

    // An invalid result is always a lone symbol I.
    a_invalid_single: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast && (m_tdata[SymW-1:0] == SYM_I))
        else $error("invalid result without tlast or with nonzero symbol");

    // While converting, something is always left to emit.
    a_run_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (rem_reg != '0) && (idx_reg <= LastRow))
        else $error("conversion running with nothing left");

    // The final symbol of a numeral returns the sequencer to idle.
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) && out_load && out_last_next |=> (state_reg == ST_IDLE))
        else $error("sequencer kept running after the final symbol");

endmodule

`default_nettype wire
